// ===== rtl/core/tgarle_pkg.sv =====
// Shared types and constants of the run-length pixel decoder.
`default_nettype none

package tgarle_pkg;

    // Configuration register indexes
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_PIXEL_TOTAL   = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_ALPHA_PRESENT = 1'd1;

    // Packet header coding
    localparam logic [7:0] RUN_BIAS = 8'd127;

    // Pixel sizes in bytes
    localparam logic [2:0] BYTES_RGB  = 3'd3;
    localparam logic [2:0] BYTES_RGBA = 3'd4;

    typedef struct packed {
        logic [31:0] pixel_total;
        logic        alpha_present;
    } tgarle_cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       image_done;
        logic       overflow;
    } tgarle_pix_t;

endpackage

`default_nettype wire

// ===== rtl/core/tgarle_if.sv =====
// Valid/ready channel interfaces for the packet byte stream and the pixel results.
`default_nettype none

interface tgarle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface tgarle_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;
    logic       overflow;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output repeat_count, output image_done, output overflow,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input repeat_count, input image_done, input overflow,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tgarle_cfg.sv =====
// Configuration registers: pixel total and alpha enable.
`default_nettype none

module tgarle_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tgarle_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_wdata,
    output tgarle_pkg::tgarle_cfg_t            cfg
);
    import tgarle_pkg::*;

    logic [31:0] pixel_total_reg;
    logic        alpha_present_reg;

    // Capture register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_total_reg   <= 32'd1;
            alpha_present_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PIXEL_TOTAL:   pixel_total_reg   <= cfg_wdata;
                CFG_ALPHA_PRESENT: alpha_present_reg <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    assign cfg.pixel_total   = pixel_total_reg;
    assign cfg.alpha_present = alpha_present_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tgarle_core.sv =====
// Input register, packet state and per-byte decode step.
`default_nettype none

module tgarle_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tgarle_pkg::tgarle_cfg_t cfg,
    tgarle_byte_if.sink               stream,
    input  wire logic                 res_ready,
    output logic                      res_load,
    output tgarle_pkg::tgarle_pix_t   res
);
    import tgarle_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic        awaiting_header_reg, awaiting_header_next;
    logic        is_run_reg,          is_run_next;
    logic        dropping_reg,        dropping_next;
    logic [7:0]  left_reg,            left_next;
    logic [1:0]  bip_reg,             bip_next;
    logic [31:0] color_reg,           color_next;
    logic [31:0] done_cnt_reg,        done_cnt_next;

    logic        advance;
    logic        emit;
    logic [2:0]  bpp;
    logic [31:0] total;
    logic [31:0] missing;
    logic [31:0] color_new;
    logic [7:0]  left_dec;
    logic [7:0]  count;
    logic        done_flag;
    logic        ovf_flag;

    // Step the held byte whenever the result side can take a result
    assign advance      = in_valid_reg && res_ready;
    assign stream.ready = !in_valid_reg || advance;

    // Hold the accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            in_byte_reg <= stream.stream_byte;
        end
    end

    // Pixel count arithmetic: a zero total acts as one
    assign bpp      = cfg.alpha_present ? BYTES_RGBA : BYTES_RGB;
    assign total    = (cfg.pixel_total == 32'd0) ? 32'd1 : cfg.pixel_total;
    assign missing  = (done_cnt_reg < total) ? (total - done_cnt_reg) : 32'd1;
    assign left_dec = left_reg - 8'd1;

    // Insert the byte at its position in the pixel
    always_comb
    begin
        color_new = color_reg;
        case (bip_reg)
            2'd0:    color_new[7:0]   = in_byte_reg;
            2'd1:    color_new[15:8]  = in_byte_reg;
            2'd2:    color_new[23:16] = in_byte_reg;
            default: color_new[31:24] = in_byte_reg;
        endcase
    end

    // Decode step
    always_comb
    begin
        awaiting_header_next = awaiting_header_reg;
        is_run_next          = is_run_reg;
        dropping_next        = dropping_reg;
        left_next            = left_reg;
        bip_next             = bip_reg;
        color_next           = color_reg;
        done_cnt_next        = done_cnt_reg;
        emit                 = 1'b0;
        count                = 8'd1;
        done_flag            = 1'b0;
        ovf_flag             = 1'b0;

        if (advance)
        begin
            if (awaiting_header_reg)
            begin
                // Open a raw packet or a run
                is_run_next          = in_byte_reg[7];
                left_next            = in_byte_reg[7] ? (in_byte_reg - RUN_BIAS)
                                                      : (in_byte_reg + 8'd1);
                awaiting_header_next = 1'b0;
                dropping_next        = 1'b0;
                bip_next             = 2'd0;
                color_next           = 32'd0;
            end
            else if (({1'b0, bip_reg} + 3'd1) < bpp)
            begin
                color_next = color_new;
                bip_next   = bip_reg + 2'd1;
            end
            else
            begin
                bip_next   = 2'd0;
                color_next = 32'd0;
                if (dropping_reg)
                begin
                    // Discard the rest of a clipped raw packet
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        dropping_next        = 1'b0;
                        awaiting_header_next = 1'b1;
                    end
                end
                else if (is_run_reg)
                begin
                    emit                 = 1'b1;
                    left_next            = 8'd0;
                    awaiting_header_next = 1'b1;
                    if ({24'd0, left_reg} >= missing)
                    begin
                        // Clip the run at the image end
                        count         = missing[7:0];
                        done_flag     = 1'b1;
                        ovf_flag      = ({24'd0, left_reg} > missing);
                        done_cnt_next = 32'd0;
                    end
                    else
                    begin
                        count         = left_reg;
                        done_cnt_next = done_cnt_reg + {24'd0, left_reg};
                    end
                end
                else
                begin
                    emit      = 1'b1;
                    left_next = left_dec;
                    if (missing == 32'd1)
                    begin
                        done_flag     = 1'b1;
                        ovf_flag      = (left_dec != 8'd0);
                        done_cnt_next = 32'd0;
                        dropping_next = (left_dec != 8'd0);
                    end
                    else
                    begin
                        done_cnt_next = done_cnt_reg + 32'd1;
                    end
                    if (left_dec == 8'd0)
                    begin
                        awaiting_header_next = 1'b1;
                    end
                end
            end
        end
    end

    // Hold packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_header_reg <= 1'b1;
            is_run_reg          <= 1'b0;
            dropping_reg        <= 1'b0;
            left_reg            <= 8'd0;
            bip_reg             <= 2'd0;
            color_reg           <= 32'd0;
            done_cnt_reg        <= 32'd0;
        end
        else
        begin
            awaiting_header_reg <= awaiting_header_next;
            is_run_reg          <= is_run_next;
            dropping_reg        <= dropping_next;
            left_reg            <= left_next;
            bip_reg             <= bip_next;
            color_reg           <= color_next;
            done_cnt_reg        <= done_cnt_next;
        end
    end

    // Result for the output register
    assign res_load         = emit;
    assign res.red          = color_new[23:16];
    assign res.green        = color_new[15:8];
    assign res.blue         = color_new[7:0];
    assign res.alpha        = cfg.alpha_present ? color_new[31:24] : 8'd0;
    assign res.repeat_count = count;
    assign res.image_done   = done_flag;
    assign res.overflow     = ovf_flag;

endmodule

`default_nettype wire

// ===== rtl/core/tgarle_outreg.sv =====
// Result register that drives the pixel channel.
`default_nettype none

module tgarle_outreg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 res_load,
    input  wire tgarle_pkg::tgarle_pix_t res,
    output logic                      res_ready,
    tgarle_pix_if.source              pixel
);
    import tgarle_pkg::*;

    logic        valid_reg;
    tgarle_pix_t pix_reg;

    // Free when empty or when the current transaction completes
    assign res_ready = !valid_reg || pixel.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_load)
        begin
            pix_reg <= res;
        end
    end

    assign pixel.valid        = valid_reg;
    assign pixel.red          = pix_reg.red;
    assign pixel.green        = pix_reg.green;
    assign pixel.blue         = pix_reg.blue;
    assign pixel.alpha        = pix_reg.alpha;
    assign pixel.repeat_count = pix_reg.repeat_count;
    assign pixel.image_done   = pix_reg.image_done;
    assign pixel.overflow     = pix_reg.overflow;

endmodule

`default_nettype wire

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
// Top level of the run-length pixel decoder.
// A byte is held in the input register, and a pixel that it completes is loaded into the result register.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or its transaction completes.
// Reset (rst_n low, asynchronous): expect a header, pixel count zero,
// pixel_total 1, alpha_present 0, both channels empty.
`default_nettype none

module tga_rle_pixel_decoder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tgarle_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_wdata,
    tgarle_byte_if.sink                        stream,
    tgarle_pix_if.source                       pixel
);
    import tgarle_pkg::*;

    tgarle_cfg_t cfg;
    tgarle_pix_t res;
    logic        res_load;
    logic        res_ready;

    tgarle_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tgarle_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .stream    (stream),
        .res_ready (res_ready),
        .res_load  (res_load),
        .res       (res)
    );

    tgarle_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .res_ready (res_ready),
        .pixel     (pixel)
    );

endmodule

`default_nettype wire

// ===== rtl/core/tgarle_chk.sv =====
// Port-level checker for the run-length pixel decoder, with its bind.
`default_nettype none

module tgarle_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_red,
    input wire logic [7:0] out_green,
    input wire logic [7:0] out_blue,
    input wire logic [7:0] out_alpha,
    input wire logic [7:0] out_repeat_count,
    input wire logic       out_image_done,
    input wire logic       out_overflow
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable({out_red, out_green, out_blue, out_alpha,
                     out_repeat_count, out_image_done, out_overflow}))
        else $error("pixel result changed while stalled");

    // Repeat count is never zero
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_repeat_count != 8'd0)
        else $error("zero repeat count");

    // Overflow only on the pixel that completes the image
    a_ovf_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_overflow |-> out_image_done)
        else $error("overflow without image done");

    // Empty result register never blocks the stream
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("stream stalled with empty result register");

endmodule

bind tga_rle_pixel_decoder tgarle_chk u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (stream.ready),
    .out_valid        (pixel.valid),
    .out_ready        (pixel.ready),
    .out_red          (pixel.red),
    .out_green        (pixel.green),
    .out_blue         (pixel.blue),
    .out_alpha        (pixel.alpha),
    .out_repeat_count (pixel.repeat_count),
    .out_image_done   (pixel.image_done),
    .out_overflow     (pixel.overflow)
);

`default_nettype wire
